### hw/rtl/stk_pkg.sv
// Shared types and constants for the data stack: field widths, operation and
// status codes, and the command and status bundles between controller and datapath.
// Depends on nothing.
`default_nettype none

package stk_pkg;

    localparam int unsigned DEPTH_DEF      = 1024;
    localparam int unsigned DATA_WIDTH_DEF = 32;

    localparam int unsigned OP_W  = 3;
    localparam int unsigned VAL_W = 32;
    localparam int unsigned OFF_W = 10;
    localparam int unsigned ST_W  = 2;
    localparam int unsigned CNT_W = 11;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 3'd0,
        OP_POP  = 3'd1,
        OP_PEEK = 3'd2,
        OP_DUP  = 3'd3,
        OP_SWAP = 3'd4,
        OP_ROT  = 3'd5
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2
    } t_status;

    // Memory address sources.
    typedef enum logic [2:0] {
        ASEL_PUSH = 3'd0,
        ASEL_TOP0 = 3'd1,
        ASEL_TOP1 = 3'd2,
        ASEL_TOP2 = 3'd3,
        ASEL_PEEK = 3'd4
    } t_asel;

    // Memory write data sources.
    typedef enum logic [1:0] {
        DSEL_VAL    = 2'd0,
        DSEL_RDATA  = 2'd1,
        DSEL_HOLD_A = 2'd2,
        DSEL_HOLD_B = 2'd3
    } t_dsel;

    typedef struct packed {
        logic    latch;
        logic    rd_en;
        t_asel   rd_asel;
        logic    wr_en;
        t_asel   wr_asel;
        t_dsel   wr_dsel;
        logic    cap_a;
        logic    cap_b;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    res_load;
        logic    res_rdata;
        t_status res_status;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
        logic lt2;
        logic lt3;
        logic peek_bad;
    } t_flags;

endpackage

`default_nettype wire

### hw/rtl/stk_in_if.sv
// Request channel of the data stack: valid/ready handshake with op, value and offset.
// Depends on stk_pkg.
`default_nettype none

interface stk_in_if;
    import stk_pkg::*;

    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  op;
    logic [VAL_W-1:0] push_value;
    logic [OFF_W-1:0] offset;

    modport source (output valid, output op, output push_value, output offset, input ready);
    modport sink   (input valid, input op, input push_value, input offset, output ready);
endinterface

`default_nettype wire

### hw/rtl/stk_out_if.sv
// Result channel of the data stack: valid/ready handshake with value, status and count.
// Depends on stk_pkg.
`default_nettype none

interface stk_out_if;
    import stk_pkg::*;

    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] read_value;
    logic [ST_W-1:0]  status;
    logic [CNT_W-1:0] count_after;

    modport source (output valid, output read_value, output status, output count_after,
                     input ready);
    modport sink   (input valid, input read_value, input status, input count_after,
                     output ready);
endinterface

`default_nettype wire

### hw/rtl/stk_datapath.sv
// Datapath of the data stack: stack memory, element count, hold registers and result register.
// Depends on stk_pkg; driven by commands from stk_ctrl.
`default_nettype none

module stk_datapath #(
    parameter int unsigned DEPTH      = stk_pkg::DEPTH_DEF,
    parameter int unsigned DATA_WIDTH = stk_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire stk_pkg::t_cmd               i_cmd,
    input  wire logic [stk_pkg::VAL_W-1:0]   i_push_value,
    input  wire logic [stk_pkg::OFF_W-1:0]   i_offset,
    output stk_pkg::t_flags                  o_flags,
    output logic      [stk_pkg::VAL_W-1:0]   o_read_value,
    output logic      [stk_pkg::ST_W-1:0]    o_status,
    output logic      [stk_pkg::CNT_W-1:0]   o_count_after
);
    import stk_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned XW = (CW > OFF_W) ? CW : OFF_W;

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    logic [DATA_WIDTH-1:0] r_value;
    logic [OFF_W-1:0]      r_off;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic [DATA_WIDTH-1:0] r_rdata;
    logic [DATA_WIDTH-1:0] r_hold_a;
    logic [DATA_WIDTH-1:0] r_hold_b;
    logic [VAL_W-1:0]      r_read_value;
    logic [ST_W-1:0]       r_status;
    logic [CNT_W-1:0]      r_count_after;

    logic [AW-1:0]         addr_push;
    logic [AW-1:0]         addr_top0;
    logic [AW-1:0]         addr_top1;
    logic [AW-1:0]         addr_top2;
    logic [XW-1:0]         peek_idx;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;

    // Element positions relative to the top; only used when the count makes them valid.
    assign addr_push = AW'(r_count);
    assign addr_top0 = AW'(r_count - CW'(1));
    assign addr_top1 = AW'(r_count - CW'(2));
    assign addr_top2 = AW'(r_count - CW'(3));
    assign peek_idx  = XW'(r_count) - XW'(1) - XW'(r_off);

    always_comb begin
        unique case (i_cmd.rd_asel)
            ASEL_PUSH: rd_addr = addr_push;
            ASEL_TOP0: rd_addr = addr_top0;
            ASEL_TOP1: rd_addr = addr_top1;
            ASEL_TOP2: rd_addr = addr_top2;
            ASEL_PEEK: rd_addr = AW'(peek_idx);
            default:   rd_addr = addr_top0;
        endcase
    end

    always_comb begin
        unique case (i_cmd.wr_asel)
            ASEL_PUSH: wr_addr = addr_push;
            ASEL_TOP0: wr_addr = addr_top0;
            ASEL_TOP1: wr_addr = addr_top1;
            ASEL_TOP2: wr_addr = addr_top2;
            ASEL_PEEK: wr_addr = AW'(peek_idx);
            default:   wr_addr = addr_push;
        endcase
    end

    always_comb begin
        unique case (i_cmd.wr_dsel)
            DSEL_VAL:    wr_data = r_value;
            DSEL_RDATA:  wr_data = r_rdata;
            DSEL_HOLD_A: wr_data = r_hold_a;
            DSEL_HOLD_B: wr_data = r_hold_b;
            default:     wr_data = r_value;
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.cnt_inc) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.cnt_dec) begin
            n_count = r_count - CW'(1);
        end
    end

    always_comb begin
        o_flags.empty    = (r_count == '0);
        o_flags.full     = (r_count == CW'(DEPTH));
        o_flags.lt2      = (r_count < CW'(2));
        o_flags.lt3      = (r_count < CW'(3));
        o_flags.peek_bad = (XW'(r_off) >= XW'(r_count));
    end

    // Stack memory: one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_value <= DATA_WIDTH'(i_push_value);
            r_off   <= i_offset;
        end
        if (i_cmd.cap_a) begin
            r_hold_a <= r_rdata;
        end
        if (i_cmd.cap_b) begin
            r_hold_b <= r_rdata;
        end
        if (i_cmd.res_load) begin
            r_read_value  <= i_cmd.res_rdata ? VAL_W'(r_rdata) : '0;
            r_status      <= i_cmd.res_status;
            r_count_after <= CNT_W'(n_count);
        end
    end

    assign o_read_value  = r_read_value;
    assign o_status      = r_status;
    assign o_count_after = r_count_after;

endmodule

`default_nettype wire

### hw/rtl/stk_ctrl.sv
// Controller of the data stack: sequences the memory reads and writes of each operation.
// Depends on stk_pkg; commands stk_datapath.
`default_nettype none

module stk_ctrl (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic [stk_pkg::OP_W-1:0]  i_op,
    input  wire logic                      i_out_ready,
    output logic                           o_out_valid,
    input  wire stk_pkg::t_flags           i_flags,
    output stk_pkg::t_cmd                  o_cmd
);
    import stk_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_POP,
        S_PEEK,
        S_DUP,
        S_SW1,
        S_SW2,
        S_SW3,
        S_RO1,
        S_RO2,
        S_RO3,
        S_RO4,
        S_RO5
    } t_state;

    t_state          r_state;
    t_state          n_state;
    logic [OP_W-1:0] r_op;
    logic            r_out_valid;
    logic            out_free;
    logic            fin;
    t_cmd            cmd;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        fin     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.latch = 1'b1;
                    n_state   = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (r_op)
                    OP_PUSH: begin
                        fin = 1'b1;
                        if (i_flags.full) begin
                            cmd.res_status = ST_OVER;
                        end else begin
                            cmd.wr_en   = 1'b1;
                            cmd.wr_asel = ASEL_PUSH;
                            cmd.wr_dsel = DSEL_VAL;
                            cmd.cnt_inc = 1'b1;
                        end
                    end
                    OP_POP: begin
                        if (i_flags.empty) begin
                            fin            = 1'b1;
                            cmd.res_status = ST_UNDER;
                        end else begin
                            cmd.rd_en   = 1'b1;
                            cmd.rd_asel = ASEL_TOP0;
                            n_state     = S_POP;
                        end
                    end
                    OP_PEEK: begin
                        if (i_flags.peek_bad) begin
                            fin            = 1'b1;
                            cmd.res_status = ST_UNDER;
                        end else begin
                            cmd.rd_en   = 1'b1;
                            cmd.rd_asel = ASEL_PEEK;
                            n_state     = S_PEEK;
                        end
                    end
                    OP_DUP: begin
                        if (i_flags.empty) begin
                            fin            = 1'b1;
                            cmd.res_status = ST_UNDER;
                        end else if (i_flags.full) begin
                            fin            = 1'b1;
                            cmd.res_status = ST_OVER;
                        end else begin
                            cmd.rd_en   = 1'b1;
                            cmd.rd_asel = ASEL_TOP0;
                            n_state     = S_DUP;
                        end
                    end
                    OP_SWAP: begin
                        if (i_flags.lt2) begin
                            fin            = 1'b1;
                            cmd.res_status = ST_UNDER;
                        end else begin
                            cmd.rd_en   = 1'b1;
                            cmd.rd_asel = ASEL_TOP0;
                            n_state     = S_SW1;
                        end
                    end
                    OP_ROT: begin
                        if (i_flags.lt3) begin
                            fin            = 1'b1;
                            cmd.res_status = ST_UNDER;
                        end else begin
                            cmd.rd_en   = 1'b1;
                            cmd.rd_asel = ASEL_TOP0;
                            n_state     = S_RO1;
                        end
                    end
                    default: begin
                        // Unused codes complete at once with an unchanged stack.
                        fin = 1'b1;
                    end
                endcase
            end
            S_POP: begin
                fin           = 1'b1;
                cmd.res_rdata = 1'b1;
                cmd.cnt_dec   = 1'b1;
            end
            S_PEEK: begin
                fin           = 1'b1;
                cmd.res_rdata = 1'b1;
            end
            S_DUP: begin
                fin         = 1'b1;
                cmd.wr_en   = 1'b1;
                cmd.wr_asel = ASEL_PUSH;
                cmd.wr_dsel = DSEL_RDATA;
                cmd.cnt_inc = 1'b1;
            end
            S_SW1: begin
                cmd.cap_a   = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rd_asel = ASEL_TOP1;
                n_state     = S_SW2;
            end
            S_SW2: begin
                cmd.wr_en   = 1'b1;
                cmd.wr_asel = ASEL_TOP0;
                cmd.wr_dsel = DSEL_RDATA;
                n_state     = S_SW3;
            end
            S_SW3: begin
                fin         = 1'b1;
                cmd.wr_en   = 1'b1;
                cmd.wr_asel = ASEL_TOP1;
                cmd.wr_dsel = DSEL_HOLD_A;
            end
            S_RO1: begin
                cmd.cap_a   = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rd_asel = ASEL_TOP1;
                n_state     = S_RO2;
            end
            S_RO2: begin
                cmd.cap_b   = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rd_asel = ASEL_TOP2;
                n_state     = S_RO3;
            end
            S_RO3: begin
                cmd.wr_en   = 1'b1;
                cmd.wr_asel = ASEL_TOP0;
                cmd.wr_dsel = DSEL_RDATA;
                n_state     = S_RO4;
            end
            S_RO4: begin
                cmd.wr_en   = 1'b1;
                cmd.wr_asel = ASEL_TOP1;
                cmd.wr_dsel = DSEL_HOLD_A;
                n_state     = S_RO5;
            end
            S_RO5: begin
                fin         = 1'b1;
                cmd.wr_en   = 1'b1;
                cmd.wr_asel = ASEL_TOP2;
                cmd.wr_dsel = DSEL_HOLD_B;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // The last step of an operation commits everything together with the result,
        // so it waits as a whole while the result register is still occupied.
        if (fin) begin
            if (out_free) begin
                cmd.res_load = 1'b1;
                n_state      = S_IDLE;
            end else begin
                cmd     = '0;
                n_state = r_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cmd.res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (cmd.latch) begin
                r_op <= i_op;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

`default_nettype wire

### hw/rtl/data_stack_with_stack_ops.sv
// Bounded LIFO data stack with push, pop, peek, dup, swap and rotate; top level.
// Each request is decoded first: push, any failed operation and unused codes finish
// there; pop, peek and dup take a further step; swap and rotate step through their
// reads and writes in turn, as the stack memory has a single write port and a single
// registered read port. A new request is taken only once the last one has finished.
// Reset clears the element count and the handshake state; the memory is not cleared.
`default_nettype none

module data_stack_with_stack_ops #(
    parameter int unsigned DEPTH      = stk_pkg::DEPTH_DEF,
    parameter int unsigned DATA_WIDTH = stk_pkg::DATA_WIDTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    stk_in_if.sink     i_cmd,
    stk_out_if.source  o_res
);
    import stk_pkg::*;

    // The controller walks each operation through its memory accesses; the datapath
    // owns the stack memory, the count and the result register. They meet only
    // through the command bundle one way and the count flags the other.
    t_cmd   cmd;
    t_flags flags;
    logic   in_ready;
    logic   out_valid;

    stk_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .o_in_ready  (in_ready),
        .i_op        (i_cmd.op),
        .i_out_ready (o_res.ready),
        .o_out_valid (out_valid),
        .i_flags     (flags),
        .o_cmd       (cmd)
    );

    stk_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_push_value  (i_cmd.push_value),
        .i_offset      (i_cmd.offset),
        .o_flags       (flags),
        .o_read_value  (o_res.read_value),
        .o_status      (o_res.status),
        .o_count_after (o_res.count_after)
    );

    // A request is taken only when the controller is idle, but the previous result
    // may still be waiting in the output register while the next one is worked on.
    assign i_cmd.ready = in_ready;
    assign o_res.valid = out_valid;

    // The count never passes the capacity and never goes below zero.
    a_no_inc_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.cnt_inc |-> !flags.full)
        else $error("count incremented on a full stack");

    a_no_dec_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.cnt_dec |-> !flags.empty)
        else $error("count decremented on an empty stack");

    // A result is only written when the previous one has gone or is leaving.
    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.res_load |-> (!o_res.valid || o_res.ready))
        else $error("result register overwritten before its transfer");

    // Only one request is worked on at a time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |=> !i_cmd.ready)
        else $error("second request taken while one is in progress");

endmodule

`default_nettype wire

### verif/stk_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the data stack: watches both channels, keeps a shadow copy of the
// stack and compares every result transfer with the oldest expected result.
// Depends on stk_pkg, stk_in_if and stk_out_if.

module stk_result_checker
    import stk_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    stk_in_if           i_cmd,
    stk_out_if          i_res,
    output int unsigned o_fail_count,
    output int unsigned o_pending
);

    typedef struct packed {
        logic [VAL_W-1:0] read_value;
        t_status          status;
        logic [CNT_W-1:0] count_after;
    } t_stack_result;

    logic [VAL_W-1:0] shadow_mem [DEPTH];
    int unsigned      shadow_count;
    t_stack_result    expected_results [$];
    t_stack_result    oldest;
    int unsigned      mismatch_count;

    initial begin
        o_fail_count   = 0;
        o_pending      = 0;
        mismatch_count = 0;
        shadow_count   = 0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: %s, got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Performs one operation on the shadow stack and returns the result it should give.
    // A failing operation leaves the shadow state untouched.
    function automatic t_stack_result apply_stack_op(input logic [OP_W-1:0]  op,
                                                     input logic [VAL_W-1:0] value,
                                                     input logic [OFF_W-1:0] depth_off);
        t_stack_result    r;
        logic [VAL_W-1:0] top_a;
        logic [VAL_W-1:0] top_b;
        logic [VAL_W-1:0] top_c;
        r.read_value = '0;
        r.status     = ST_OK;
        case (op)
            OP_PUSH: begin
                if (shadow_count >= DEPTH) begin
                    r.status = ST_OVER;
                end else begin
                    shadow_mem[shadow_count] = value;
                    shadow_count++;
                end
            end
            OP_POP: begin
                if (shadow_count == 0) begin
                    r.status = ST_UNDER;
                end else begin
                    shadow_count--;
                    r.read_value = shadow_mem[shadow_count];
                end
            end
            OP_PEEK: begin
                if (depth_off >= shadow_count) begin
                    r.status = ST_UNDER;
                end else begin
                    r.read_value = shadow_mem[shadow_count - 1 - depth_off];
                end
            end
            OP_DUP: begin
                if (shadow_count == 0) begin
                    r.status = ST_UNDER;
                end else if (shadow_count >= DEPTH) begin
                    r.status = ST_OVER;
                end else begin
                    shadow_mem[shadow_count] = shadow_mem[shadow_count - 1];
                    shadow_count++;
                end
            end
            OP_SWAP: begin
                if (shadow_count < 2) begin
                    r.status = ST_UNDER;
                end else begin
                    top_a = shadow_mem[shadow_count - 1];
                    shadow_mem[shadow_count - 1] = shadow_mem[shadow_count - 2];
                    shadow_mem[shadow_count - 2] = top_a;
                end
            end
            OP_ROT: begin
                // A B C (top first) becomes C A B.
                if (shadow_count < 3) begin
                    r.status = ST_UNDER;
                end else begin
                    top_a = shadow_mem[shadow_count - 1];
                    top_b = shadow_mem[shadow_count - 2];
                    top_c = shadow_mem[shadow_count - 3];
                    shadow_mem[shadow_count - 1] = top_c;
                    shadow_mem[shadow_count - 2] = top_a;
                    shadow_mem[shadow_count - 3] = top_b;
                end
            end
            default: begin
            end
        endcase
        r.count_after = CNT_W'(shadow_count);
        return r;
    endfunction

    // Results are compared before new requests are predicted: a result can never
    // belong to a request accepted at the same edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shadow_count = 0;
            expected_results.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result transfer with nothing outstanding",
                                    i_res.read_value, '0);
                end else begin
                    oldest = expected_results.pop_front();
                    if (i_res.read_value !== oldest.read_value)
                        report_mismatch("read_value", i_res.read_value, oldest.read_value);
                    if (i_res.status !== oldest.status)
                        report_mismatch("status", 32'(i_res.status), 32'(oldest.status));
                    if (i_res.count_after !== oldest.count_after)
                        report_mismatch("count_after", 32'(i_res.count_after),
                                        32'(oldest.count_after));
                end
            end
            if (i_cmd.valid && i_cmd.ready) begin
                expected_results.push_back(apply_stack_op(i_cmd.op, i_cmd.push_value,
                                                          i_cmd.offset));
            end
        end
        o_pending    <= expected_results.size();
        o_fail_count <= mismatch_count;
    end

endmodule

### verif/tb_data_stack_with_stack_ops.sv
`timescale 1ns / 1ps
// Top of the data stack testbench: clock, reset, request stimulus, result back-pressure,
// watchdog and verdict. Checking is done by stk_result_checker beside the block.
// Depends on stk_pkg, stk_in_if, stk_out_if, stk_result_checker and the block itself.

module tb_data_stack_with_stack_ops;
    import stk_pkg::*;

    localparam int unsigned STACK_DEPTH = DEPTH_DEF;

    // Operation codes the block does not define; it must treat them as a no-op.
    localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

    // Cycles without any transfer on either channel before the run is declared hung.
    // The slowest legitimate gap is a sender pause on top of a rotate and a receiver
    // stall, so this is generous.
    localparam int unsigned STALL_LIMIT = 2000;

    // Cycles allowed after the last expected result for anything stray to show up; the
    // slowest operation is rotate.
    localparam int unsigned SETTLE_CYCLES = 16;

    logic        clk = 1'b0;
    logic        rst_n;
    int unsigned fail_count;
    int unsigned pending;
    logic        quiet_tail;
    logic [CNT_W-1:0] seen_count;
    int unsigned idle_cycles;
    int unsigned ready_hold;

    stk_in_if  cmd_if ();
    stk_out_if res_if ();

    data_stack_with_stack_ops u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    stk_result_checker #(
        .DEPTH (STACK_DEPTH)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cmd        (cmd_if),
        .i_res        (res_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 20 ns period, starting low.
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // The last count reported by the block. It is only used to steer the stimulus
    // (when to stop filling, where the peek boundary lies), never for checking.
    always @(posedge clk) begin
        if (!rst_n) begin
            seen_count <= '0;
        end else if (res_if.valid && res_if.ready) begin
            seen_count <= res_if.count_after;
        end
    end

    // Result back-pressure: ready is held for random stretches, and now and then
    // dropped for bursts of random length. In the quiet tail it stays high
    // once the current stretch has run out.
    always @(posedge clk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            res_if.ready <= 1'b0;
            ready_hold   <= $urandom_range(0, 7);
        end else begin
            res_if.ready <= 1'b1;
            ready_hold   <= $urandom_range(0, 15);
        end
    end

    // Watchdog: any transfer, on either side, restarts the count.
    always @(posedge clk) begin
        if (!rst_n || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("data_stack_with_stack_ops test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Presents one request and returns at the edge where it is transferred. The
    // caller then either presents the next request or drops valid in that same step,
    // so valid only ever gets one assignment per edge.
    task automatic send_request(input logic [OP_W-1:0]  op,
                                input logic [VAL_W-1:0] value,
                                input logic [OFF_W-1:0] depth_off);
        cmd_if.valid      <= 1'b1;
        cmd_if.op         <= op;
        cmd_if.push_value <= value;
        cmd_if.offset     <= depth_off;
        @(posedge clk);
        while (!cmd_if.ready) @(posedge clk);
    endtask

    task automatic pause_sender(input int unsigned cycles);
        cmd_if.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Holds the request side quiet until every outstanding result has come back.
    // The first edge lets the checker's count catch up with the last transfer.
    task automatic wait_for_results();
        cmd_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Picks an operation: push and pop by the given percentages, the remainder
    // spread over peek, dup, swap and rotate, with an occasional unused code.
    function automatic logic [OP_W-1:0] random_op(input int unsigned push_pct,
                                                  input int unsigned pop_pct);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < push_pct) return OP_PUSH;
        if (roll < push_pct + pop_pct) return OP_POP;
        case ($urandom_range(0, 8))
            0, 1:    return OP_PEEK;
            2, 3:    return OP_DUP;
            4, 5:    return OP_SWAP;
            6, 7:    return OP_ROT;
            default: return $urandom_range(0, 1) ? OP_UNUSED_HI : OP_UNUSED_LO;
        endcase
    endfunction

    function automatic logic [VAL_W-1:0] random_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return VAL_W'($urandom());
        endcase
    endfunction

    // Peek depths: mostly shallow, some anywhere in the 10-bit range, and some at or just
    // below the current count so that both sides of the bound get hit.
    function automatic logic [OFF_W-1:0] random_offset();
        int unsigned near_edge;
        case ($urandom_range(0, 3))
            0: return OFF_W'($urandom_range(0, 3));
            1: return OFF_W'($urandom_range(0, 1023));
            2: begin
                near_edge = seen_count;
                if (near_edge > 2) near_edge = near_edge - $urandom_range(0, 2);
                return OFF_W'(near_edge);
            end
            default: return OFF_W'($urandom_range(0, 7));
        endcase
    endfunction

    // A run of random requests. It stops early once the block reports a count equal
    // to stop_at (a negative value never stops). The sender pauses in random bursts,
    // except in every last quarter of a 64-request window and in the quiet tail.
    task automatic run_random(input int unsigned n_max, input int unsigned push_pct,
                              input int unsigned pop_pct, input int stop_at);
        int unsigned n;
        for (n = 0; n < n_max; n++) begin
            if (stop_at >= 0 && int'(seen_count) == stop_at) break;
            send_request(random_op(push_pct, pop_pct), random_value(), random_offset());
            if (!quiet_tail && (n % 64) < 48 && $urandom_range(0, 3) == 0)
                pause_sender($urandom_range(1, 8));
        end
    endtask

    initial begin
        rst_n             = 1'b0;
        quiet_tail        = 1'b0;
        ready_hold        = 0;
        idle_cycles       = 0;
        res_if.ready      = 1'b0;
        cmd_if.valid      = 1'b0;
        cmd_if.op         = OP_PUSH;
        cmd_if.push_value = '0;
        cmd_if.offset     = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening. Every operation on an empty stack must fail, and the
        // unused codes must come back as harmless no-ops.
        send_request(OP_POP,  '0, '0);
        send_request(OP_DUP,  '0, '0);
        send_request(OP_SWAP, '0, '0);
        send_request(OP_ROT,  '0, '0);
        send_request(OP_PEEK, '0, '0);
        send_request(OP_UNUSED_LO, '1, '1);
        send_request(OP_UNUSED_HI, '0, '0);
        // Two elements: swap works, rotate still lacks a third.
        send_request(OP_PUSH, '1, '0);
        send_request(OP_PUSH, '0, '1);
        send_request(OP_SWAP, '0, '0);
        send_request(OP_ROT,  '0, '0);
        // Three elements: rotate, then peek across and just past the bottom.
        send_request(OP_PUSH, 32'hA5A5_5A5A, '0);
        send_request(OP_ROT,  '0, '0);
        send_request(OP_PEEK, '0, '0);
        send_request(OP_PEEK, '0, 10'd2);
        send_request(OP_PEEK, '0, 10'd3);
        send_request(OP_PEEK, '0, '1);
        send_request(OP_DUP,  '0, '0);
        send_request(OP_SWAP, '0, '0);
        // Empty it again, ending with one pop too many.
        repeat (5) send_request(OP_POP, '0, '0);

        // Shallow, balanced traffic with plenty of underflows.
        run_random(150, 40, 30, -1);
        // Fill the stack to the top; the requests still in flight when the full
        // count is reported become overflowing pushes and dups.
        run_random(1300, 82, 2, STACK_DEPTH);
        // Work at the top: overflows, deep peeks and pops refilled by pushes.
        run_random(60, 35, 10, -1);

        // Hold off completely once, so the block runs dry.
        wait_for_results();

        // Drain part of the way down.
        run_random(320, 10, 60, -1);

        // Final stretch with no idling on either side.
        quiet_tail <= 1'b1;
        run_random(200, 30, 30, -1);

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("data_stack_with_stack_ops test passed");
        end else begin
            $display("data_stack_with_stack_ops test failed");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/stk_pkg.sv
hw/rtl/stk_in_if.sv
hw/rtl/stk_out_if.sv
hw/rtl/stk_datapath.sv
hw/rtl/stk_ctrl.sv
hw/rtl/data_stack_with_stack_ops.sv
verif/stk_result_checker.sv
verif/tb_data_stack_with_stack_ops.sv
